FILE: hdl/terminal_line_editor_defines.svh
// Assertion macros shared by the terminal line editor RTL.
`ifndef TERMINAL_LINE_EDITOR_DEFINES_SVH
`define TERMINAL_LINE_EDITOR_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define TLE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("terminal_line_editor: check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define TLE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("terminal_line_editor: check failed");

`endif

FILE: hdl/tle_pkg.sv
// Types, codes and echo sequence tables of the terminal line editor.
package tle_pkg;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_RX    = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [2:0] SEQ_PROMPT = 3'd0;
    localparam logic [2:0] SEQ_ERASE  = 3'd1;
    localparam logic [2:0] SEQ_RUBOUT = 3'd2;
    localparam logic [2:0] SEQ_ECHO   = 3'd3;
    localparam logic [2:0] SEQ_DONE   = 3'd4;
    localparam logic [2:0] SEQ_READ   = 3'd5;

    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NAK   = 8'h15;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_K     = 8'h4B;

    typedef struct packed {
        logic [2:0] seq;
        logic [7:0] echo_byte;
        logic [7:0] len;
        logic       rd_ok;
    } t_load;

    function automatic logic [2:0] seq_last(input logic [2:0] seq);
        logic [2:0] r;
        case (seq)
            SEQ_PROMPT: r = 3'd3;
            SEQ_ERASE:  r = 3'd6;
            SEQ_RUBOUT: r = 3'd2;
            default:    r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] seq_byte(input logic [2:0] seq, input logic [2:0] pos);
        logic [7:0] r;
        r = 8'h00;
        case (seq)
            SEQ_PROMPT: begin
                case (pos)
                    3'd0:    r = CH_CR;
                    3'd1:    r = CH_LF;
                    3'd2:    r = CH_GT;
                    3'd3:    r = CH_SPACE;
                    default: r = 8'h00;
                endcase
            end
            SEQ_ERASE: begin
                case (pos)
                    3'd0:    r = CH_CR;
                    3'd1:    r = CH_ESC;
                    3'd2:    r = CH_LBRK;
                    3'd3:    r = CH_TWO;
                    3'd4:    r = CH_K;
                    3'd5:    r = CH_GT;
                    3'd6:    r = CH_SPACE;
                    default: r = 8'h00;
                endcase
            end
            SEQ_RUBOUT: begin
                case (pos)
                    3'd0:    r = CH_BS;
                    3'd1:    r = CH_SPACE;
                    3'd2:    r = CH_BS;
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/tle_if.sv
// Request and response channel interfaces of the terminal line editor.
interface tle_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic [7:0] read_index;

    modport source (output valid, command, rx_byte, read_index, input ready);
    modport sink   (input valid, command, rx_byte, read_index, output ready);
endinterface

interface tle_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [7:0] line_length;
    logic       last;

    modport source (output valid, out_kind, out_byte, line_length, last, input ready);
    modport sink   (input valid, out_kind, out_byte, line_length, last, output ready);
endinterface

FILE: hdl/terminal_line_editor.sv
// Terminal line editor top level: line buffer memory, edit control and result sequencer.
// Each accepted request is decoded in the cycle it transfers; its results then come out one per
// cycle while o_rsp.ready is high: a read, an echoed character or a line-finished report is 1
// result, a rubout 3, a prompt 4 and a clear-line redraw 7, and a dropped byte none. The next
// request is taken in the cycle the final result of the current one transfers, as the single
// result register holds one item at a time. The line bytes live in a LINE_DEPTH-entry memory
// with a registered read port; read data is ready the cycle after the read request transfers.
`include "terminal_line_editor_defines.svh"

module terminal_line_editor #(
    parameter int LINE_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    tle_req_if.sink    i_req,
    tle_rsp_if.source  o_rsp
);

    localparam int AW  = $clog2(LINE_DEPTH);
    localparam int AXW = AW + 8;

    logic [7:0] r_line_mem [LINE_DEPTH];
    logic [7:0] r_rdata;
    logic [7:0] r_line_size;
    logic [7:0] r_count;
    logic       r_open;

    logic [7:0]     n_count;
    logic           n_open;
    logic           acc;
    logic           seq_free;
    logic           ld_en;
    tle_pkg::t_load ld;
    logic           we;
    logic           rd_en;
    logic [7:0]     cap8;
    logic           full;
    logic [7:0]     b;
    logic [AXW-1:0] wr_wide;
    logic [AXW-1:0] rd_wide;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;

    assign i_req.ready = seq_free;
    assign acc         = i_req.valid && seq_free;
    assign b           = i_req.rx_byte;

    assign wr_wide = {{AW{1'b0}}, r_count};
    assign rd_wide = {{AW{1'b0}}, i_req.read_index};
    assign wr_addr = wr_wide[AW-1:0];
    assign rd_addr = rd_wide[AW-1:0];

    assign cap8 = (r_line_size == 8'd0) ? 8'd0 : r_line_size - 8'd1;
    assign full = (r_count >= cap8) || (32'(r_count) >= 32'(LINE_DEPTH - 1));

    always_comb begin
        n_count      = r_count;
        n_open       = r_open;
        ld_en        = 1'b0;
        ld.seq       = tle_pkg::SEQ_DONE;
        ld.echo_byte = b;
        ld.len       = r_count;
        ld.rd_ok     = 1'b0;
        we           = 1'b0;
        rd_en        = 1'b0;
        if (acc) begin
            case (i_req.command)
                tle_pkg::CMD_START: begin
                    n_count = 8'd0;
                    ld_en   = 1'b1;
                    ld.len  = 8'd0;
                    if (r_line_size <= 8'd1) begin
                        n_open = 1'b0;
                        ld.seq = tle_pkg::SEQ_DONE;
                    end else begin
                        n_open = 1'b1;
                        ld.seq = tle_pkg::SEQ_PROMPT;
                    end
                end
                tle_pkg::CMD_READ: begin
                    rd_en    = 1'b1;
                    ld_en    = 1'b1;
                    ld.seq   = tle_pkg::SEQ_READ;
                    ld.rd_ok = (i_req.read_index < r_count);
                end
                tle_pkg::CMD_RX: begin
                    if (r_open) begin
                        if (b inside {tle_pkg::CH_ETX, tle_pkg::CH_EOT, tle_pkg::CH_NAK}) begin
                            n_count = 8'd0;
                            ld_en   = 1'b1;
                            ld.seq  = tle_pkg::SEQ_ERASE;
                            ld.len  = 8'd0;
                        end else if (b inside {tle_pkg::CH_BS, tle_pkg::CH_DEL}) begin
                            if (r_count != 8'd0) begin
                                n_count = r_count - 8'd1;
                                ld_en   = 1'b1;
                                ld.seq  = tle_pkg::SEQ_RUBOUT;
                                ld.len  = r_count - 8'd1;
                            end
                        end else if (b inside {tle_pkg::CH_LF, tle_pkg::CH_CR}) begin
                            n_open = 1'b0;
                            ld_en  = 1'b1;
                            ld.seq = tle_pkg::SEQ_DONE;
                        end else if (b inside {[tle_pkg::CH_SPACE:8'h7E]}) begin
                            if (!full) begin
                                we      = 1'b1;
                                n_count = r_count + 8'd1;
                                ld_en   = 1'b1;
                                ld.seq  = tle_pkg::SEQ_ECHO;
                                ld.len  = r_count + 8'd1;
                            end
                        end
                    end
                end
                default: begin
                    ld_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= 8'd0;
            r_open      <= 1'b0;
            r_line_size <= 8'd64;
        end else begin
            r_count <= n_count;
            r_open  <= n_open;
            if (i_cfg_we) begin
                r_line_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_line_mem[wr_addr] <= b;
        end
        if (rd_en) begin
            r_rdata <= r_line_mem[rd_addr];
        end
    end

    tle_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load_en (ld_en),
        .i_load    (ld),
        .i_rdata   (r_rdata),
        .o_free    (seq_free),
        .o_rsp     (o_rsp)
    );

    `TLE_ASSERT_IMP(a_len_matches_count, o_rsp.valid, o_rsp.line_length == r_count)
    `TLE_ASSERT_IMP(a_done_closes_line, o_rsp.valid && o_rsp.out_kind == tle_pkg::KIND_DONE,
                    !r_open)
    `TLE_ASSERT_IMP(a_accept_on_final, acc && o_rsp.valid, o_rsp.ready && o_rsp.last)
    `TLE_ASSERT_NXT(a_prompt_starts_cr,
                    acc && i_req.command == tle_pkg::CMD_START && r_line_size > 8'd1,
                    o_rsp.valid && o_rsp.out_byte == tle_pkg::CH_CR)

endmodule

FILE: hdl/tle_seq.sv
// Result sequencer: holds one decoded item and plays out its result bytes.
module tle_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load_en,
    input  tle_pkg::t_load  i_load,
    input  logic [7:0]      i_rdata,
    output logic            o_free,
    tle_rsp_if.source       o_rsp
);

    logic       r_busy;
    logic [2:0] r_seq;
    logic [2:0] r_pos;
    logic [7:0] r_echo;
    logic [7:0] r_len;
    logic       r_rd_ok;
    logic       is_last;
    logic       xfer;

    assign is_last = (r_pos == tle_pkg::seq_last(r_seq));
    assign xfer    = o_rsp.valid && o_rsp.ready;
    assign o_free  = !r_busy || (xfer && is_last);

    assign o_rsp.valid       = r_busy;
    assign o_rsp.last        = is_last;
    assign o_rsp.line_length = r_len;

    always_comb begin
        case (r_seq)
            tle_pkg::SEQ_DONE: o_rsp.out_kind = tle_pkg::KIND_DONE;
            tle_pkg::SEQ_READ: o_rsp.out_kind = tle_pkg::KIND_READ;
            default:           o_rsp.out_kind = tle_pkg::KIND_ECHO;
        endcase
    end

    always_comb begin
        case (r_seq)
            tle_pkg::SEQ_ECHO: o_rsp.out_byte = r_echo;
            tle_pkg::SEQ_READ: o_rsp.out_byte = r_rd_ok ? i_rdata : 8'h00;
            tle_pkg::SEQ_DONE: o_rsp.out_byte = 8'h00;
            default:           o_rsp.out_byte = tle_pkg::seq_byte(r_seq, r_pos);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= 3'd0;
        end else if (i_load_en) begin
            r_busy <= 1'b1;
            r_pos  <= 3'd0;
        end else if (xfer) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_pos <= r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_en) begin
            r_seq   <= i_load.seq;
            r_echo  <= i_load.echo_byte;
            r_len   <= i_load.len;
            r_rd_ok <= i_load.rd_ok;
        end
    end

endmodule
